// ----- design/zodm_pkg.sv -----
`default_nettype none

package zodm_pkg;

	localparam int unsigned FIELD_HEIGHT = 2000;

	localparam int unsigned BOUND_W = 12;
	localparam int unsigned POS_W   = 16;
	localparam int unsigned TIME_W  = 32;
	localparam int unsigned CMP_W   = 17;

	localparam int unsigned Q_DEPTH = 4;
	localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
	localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

	localparam logic OP_POS = 1'b0;
	localparam logic OP_EOF = 1'b1;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_X_BOUND_A       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_X_BOUND_B       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_Y_BOUND_A       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_Y_BOUND_B       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DWELL_THRESHOLD = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MIRROR_Y        = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ZONE_ON         = 3'd6;

	typedef enum logic [1:0] {
		ST_EMPTY    = 2'd0,
		ST_OCCUPIED = 2'd1,
		ST_DWELL    = 2'd2,
		ST_LEFT     = 2'd3
	} zone_st_t;

	typedef struct packed {
		logic                     operation;
		logic signed [POS_W-1:0]  pos_x;
		logic signed [POS_W-1:0]  pos_y;
		logic [TIME_W-1:0]        now_time;
	} in_word_t;

	typedef struct packed {
		logic [1:0]        zone_state;
		logic [TIME_W-1:0] presence_time;
		logic              entered;
		logic              dwell_reached;
		logic              left;
	} out_word_t;

	typedef struct packed {
		logic [BOUND_W-1:0] x_bound_a;
		logic [BOUND_W-1:0] x_bound_b;
		logic [BOUND_W-1:0] y_bound_a;
		logic [BOUND_W-1:0] y_bound_b;
		logic               mirror_y;
		logic               zone_on;
	} zone_cfg_t;

	typedef struct packed {
		logic              is_eof;
		logic              hit;
		logic [TIME_W-1:0] now_time;
	} item_t;

endpackage

`default_nettype wire

// ----- design/zodm_front.sv -----
`default_nettype none

module zodm_front
	import zodm_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire zone_cfg_t zone_cfg,
	input  wire logic      item_valid,
	output logic           item_ready,
	input  wire in_word_t  item,
	output logic           push_valid,
	input  wire logic      push_ready,
	output item_t          push_item
);

	localparam logic signed [CMP_W-1:0] FH = CMP_W'(FIELD_HEIGHT);

	logic signed [CMP_W-1:0] xa, xb, ya, yb, px, py;
	logic signed [CMP_W-1:0] x_lo, x_hi, y_lo, y_hi;
	logic                    hit;
	logic                    valid_s1;
	item_t                   item_s1;

	always_comb begin
		xa = $signed({{(CMP_W-BOUND_W){1'b0}}, zone_cfg.x_bound_a});
		xb = $signed({{(CMP_W-BOUND_W){1'b0}}, zone_cfg.x_bound_b});
		ya = $signed({{(CMP_W-BOUND_W){1'b0}}, zone_cfg.y_bound_a});
		yb = $signed({{(CMP_W-BOUND_W){1'b0}}, zone_cfg.y_bound_b});
		if (zone_cfg.mirror_y) begin
			ya = FH - ya;
			yb = FH - yb;
		end
		px = CMP_W'(item.pos_x);
		py = CMP_W'(item.pos_y);
		x_lo = (xa < xb) ? xa : xb;
		x_hi = (xa < xb) ? xb : xa;
		y_lo = (ya < yb) ? ya : yb;
		y_hi = (ya < yb) ? yb : ya;
		hit = zone_cfg.zone_on && (px >= x_lo) && (px <= x_hi)
			&& (py >= y_lo) && (py <= y_hi);
	end

	assign item_ready = !valid_s1 || push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1.is_eof   <= (item.operation == OP_EOF);
			item_s1.hit      <= hit;
			item_s1.now_time <= item.now_time;
		end
	end

	assign push_valid = valid_s1;
	assign push_item  = item_s1;

endmodule

`default_nettype wire

// ----- design/zodm_queue.sv -----
`default_nettype none

module zodm_queue
	import zodm_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push_valid,
	output logic       push_ready,
	input  wire item_t push_item,
	output logic       pop_valid,
	input  wire logic  pop_ready,
	output item_t      pop_item
);

	item_t              mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;
	logic               do_push, do_pop;

	assign push_ready = (count_q != Q_CNT_W'(Q_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

// ----- design/zodm_back.sv -----
`default_nettype none

module zodm_back
	import zodm_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [TIME_W-1:0] dwell_threshold,
	input  wire logic              pop_valid,
	output logic                   pop_ready,
	input  wire item_t             pop_item,
	output logic                   result_valid,
	input  wire logic              result_ready,
	output out_word_t              result
);

	zone_st_t          state_q, state_nxt;
	logic              seen_q;
	logic [TIME_W-1:0] entry_time_q, elapsed_q, diff;
	logic              dwell_hit, step;
	logic              entered, dwell_pulse, left_pulse, upd_elapsed;
	logic              out_valid_q;
	out_word_t         out_q;

	assign pop_ready = !pop_item.is_eof || !out_valid_q || result_ready;
	assign step      = pop_valid && pop_ready && pop_item.is_eof;
	assign diff      = pop_item.now_time - entry_time_q;
	assign dwell_hit = (dwell_threshold != '0) && (diff > dwell_threshold);

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_EMPTY: begin
				if (seen_q) state_nxt = ST_OCCUPIED;
			end
			ST_OCCUPIED: begin
				if (!seen_q) state_nxt = ST_LEFT;
				else if (dwell_hit) state_nxt = ST_DWELL;
			end
			ST_DWELL: begin
				if (!seen_q) state_nxt = ST_LEFT;
			end
			ST_LEFT: begin
				state_nxt = ST_EMPTY;
			end
			default: begin
				state_nxt = ST_EMPTY;
			end
		endcase
	end

	// pulses and updates
	always_comb begin
		entered     = 1'b0;
		dwell_pulse = 1'b0;
		left_pulse  = 1'b0;
		upd_elapsed = 1'b0;
		case (state_q)
			ST_EMPTY: begin
				entered = seen_q;
			end
			ST_OCCUPIED: begin
				upd_elapsed = seen_q;
				dwell_pulse = seen_q && dwell_hit;
			end
			ST_DWELL: begin
				entered = 1'b0;
			end
			ST_LEFT: begin
				left_pulse = 1'b1;
			end
			default: begin
				left_pulse = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_EMPTY;
			seen_q       <= 1'b0;
			entry_time_q <= '0;
			elapsed_q    <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (pop_valid && pop_ready && !pop_item.is_eof) begin
				seen_q <= seen_q | pop_item.hit;
			end
			if (step) begin
				state_q <= state_nxt;
				seen_q  <= 1'b0;
				if (entered) begin
					entry_time_q <= pop_item.now_time;
				end
				if (upd_elapsed) begin
					elapsed_q <= diff;
				end
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_q.zone_state    <= state_nxt;
			out_q.presence_time <= upd_elapsed ? diff : elapsed_q;
			out_q.entered       <= entered;
			out_q.dwell_reached <= dwell_pulse;
			out_q.left          <= left_pulse;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

`default_nettype wire

// ----- design/zone_occupancy_dwell_monitor_top.sv -----
`default_nettype none

// Monitors one rectangular zone. Position words (operation 0) are tested against
// the rectangle (inclusive, bounds in either order, y bounds optionally mirrored
// about the field height) and give no result; an end-of-frame word (operation 1)
// steps the empty / occupied / dwell / just-left machine and gives one result word.
// One word is accepted per cycle while the queue has room: the front registers the
// rectangle test, a four-entry queue follows, and the back retires one queue entry per
// cycle into an output register, stalling only when an end-of-frame result finds that
// register still full. With the queue empty, an end-of-frame word passes the front
// register and a queue entry before its result lands in the output register.
// Write the configuration registers only while the block is idle.
module zone_occupancy_dwell_monitor_top
	import zodm_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  item_valid,
	output logic                       item_ready,
	input  wire in_word_t              item,
	output logic                       result_valid,
	input  wire logic                  result_ready,
	output out_word_t                  result
);

	zone_cfg_t         zone_cfg_q;
	logic [TIME_W-1:0] dwell_threshold_q;
	logic              push_valid, push_ready, pop_valid, pop_ready;
	item_t             push_item, pop_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_cfg_q        <= '0;
			dwell_threshold_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_X_BOUND_A:       zone_cfg_q.x_bound_a <= cfg_data[BOUND_W-1:0];
				REG_X_BOUND_B:       zone_cfg_q.x_bound_b <= cfg_data[BOUND_W-1:0];
				REG_Y_BOUND_A:       zone_cfg_q.y_bound_a <= cfg_data[BOUND_W-1:0];
				REG_Y_BOUND_B:       zone_cfg_q.y_bound_b <= cfg_data[BOUND_W-1:0];
				REG_DWELL_THRESHOLD: dwell_threshold_q    <= cfg_data[TIME_W-1:0];
				REG_MIRROR_Y:        zone_cfg_q.mirror_y  <= cfg_data[0];
				REG_ZONE_ON:         zone_cfg_q.zone_on   <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	zodm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.zone_cfg   (zone_cfg_q),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	zodm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	zodm_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.dwell_threshold (dwell_threshold_q),
		.pop_valid       (pop_valid),
		.pop_ready       (pop_ready),
		.pop_item        (pop_item),
		.result_valid    (result_valid),
		.result_ready    (result_ready),
		.result          (result)
	);

endmodule

`default_nettype wire

// ----- tb/sv/tb_zone_occupancy_dwell_monitor_top.sv -----
`default_nettype none

module tb_zone_occupancy_dwell_monitor_top;
	import zodm_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT_CYCLES = 1000000;
	localparam int IDLE_CYCLES  = 12;
	localparam int DRAIN_CYCLES = 20;
	localparam int PHASES       = 14;
	localparam int PHASE_WORDS  = 125;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  item_valid;
	logic                  item_ready;
	in_word_t              item;
	logic                  result_valid;
	logic                  result_ready;
	out_word_t             result;

	zone_occupancy_dwell_monitor_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	// predicted zone state and its own copy of the registers
	zone_cfg_t   zone_regs = '0;
	logic [31:0] dwell_limit = '0;
	bit          frame_hit = 0;
	zone_st_t    occ_state = ST_EMPTY;
	logic [31:0] entry_stamp = '0;
	logic [31:0] dwell_elapsed = '0;
	out_word_t   expected_results[$];

	// stimulus side view of the current rectangle
	int          g_xlo, g_xhi, g_ylo, g_yhi;
	logic [31:0] cur_time;
	bit          quiet = 0;
	int          rdy_hold = 0;

	int cycle_count = 0;
	int err_count = 0;
	int words_sent = 0;
	int results_checked = 0;
	int settings_used = 0;
	int n_entered = 0;
	int n_dwell = 0;
	int n_left = 0;

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		item_valid = 1'b0;
		item = '0;
		result_ready = 1'b0;
	end

	always #4 clk = ~clk;

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 88)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		else
			return $urandom_range(20, 60);
	endfunction

	function automatic bit in_range(int v, int a, int b);
		int lo, hi;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		return (v >= lo) && (v <= hi);
	endfunction

	function automatic bit in_zone(int px, int py);
		int ya, yb;
		ya = int'(zone_regs.y_bound_a);
		yb = int'(zone_regs.y_bound_b);
		if (zone_regs.mirror_y) begin
			ya = int'(FIELD_HEIGHT) - ya;
			yb = int'(FIELD_HEIGHT) - yb;
		end
		return in_range(px, int'(zone_regs.x_bound_a), int'(zone_regs.x_bound_b)) &&
			in_range(py, ya, yb);
	endfunction

	function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
		case (idx)
			REG_X_BOUND_A:       zone_regs.x_bound_a = d[BOUND_W-1:0];
			REG_X_BOUND_B:       zone_regs.x_bound_b = d[BOUND_W-1:0];
			REG_Y_BOUND_A:       zone_regs.y_bound_a = d[BOUND_W-1:0];
			REG_Y_BOUND_B:       zone_regs.y_bound_b = d[BOUND_W-1:0];
			REG_DWELL_THRESHOLD: dwell_limit = d;
			REG_MIRROR_Y:        zone_regs.mirror_y = d[0];
			REG_ZONE_ON:         zone_regs.zone_on = d[0];
			default: ;
		endcase
	endfunction

	function automatic void zone_step(in_word_t w);
		out_word_t r;
		int px, py;
		r = '0;
		px = $signed(w.pos_x);
		py = $signed(w.pos_y);
		if (w.operation == OP_POS) begin
			if (zone_regs.zone_on && in_zone(px, py))
				frame_hit = 1;
			return;
		end
		case (occ_state)
			ST_EMPTY: begin
				if (frame_hit) begin
					occ_state = ST_OCCUPIED;
					entry_stamp = w.now_time;
					r.entered = 1'b1;
				end
			end
			ST_OCCUPIED: begin
				if (!frame_hit) begin
					occ_state = ST_LEFT;
				end else begin
					dwell_elapsed = w.now_time - entry_stamp;
					if (dwell_limit != 0 && dwell_elapsed > dwell_limit) begin
						occ_state = ST_DWELL;
						r.dwell_reached = 1'b1;
					end
				end
			end
			ST_DWELL: begin
				if (!frame_hit)
					occ_state = ST_LEFT;
			end
			default: begin
				occ_state = ST_EMPTY;
				r.left = 1'b1;
			end
		endcase
		frame_hit = 0;
		r.zone_state = occ_state;
		r.presence_time = dwell_elapsed;
		expected_results.push_back(r);
	endfunction

	function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
			err_count++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && item_ready)
				zone_step(item);
			if (cfg_we)
				apply_reg(cfg_idx, cfg_data);
			if (result_valid && result_ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result word, expected none actual %0h",
						$time, result);
					err_count++;
				end else begin
					out_word_t e;
					e = expected_results.pop_front();
					check_field("zone_state", 32'(e.zone_state), 32'(result.zone_state));
					check_field("presence_time", e.presence_time, result.presence_time);
					check_field("entered", 32'(e.entered), 32'(result.entered));
					check_field("dwell_reached", 32'(e.dwell_reached),
						32'(result.dwell_reached));
					check_field("left", 32'(e.left), 32'(result.left));
					results_checked++;
				end
				n_entered += int'(result.entered);
				n_dwell += int'(result.dwell_reached);
				n_left += int'(result.left);
			end
		end
	end

	// receiver stalls
	always @(posedge clk) begin
		if (rdy_hold > 0) begin
			rdy_hold <= rdy_hold - 1;
			result_ready <= 1'b0;
		end else if (quiet || $urandom_range(0, 3) != 0) begin
			result_ready <= 1'b1;
		end else begin
			result_ready <= 1'b0;
			rdy_hold <= gap_len();
		end
	end

	initial begin
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("zone_occupancy_dwell_monitor_top test failed");
		$finish;
	end

	task automatic send_word(input in_word_t w);
		int gap;
		gap = quiet ? 0 : gap_len();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= w;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		words_sent++;
	endtask

	task automatic send_pos(input int x, input int y);
		in_word_t w;
		w.operation = OP_POS;
		w.pos_x = x[POS_W-1:0];
		w.pos_y = y[POS_W-1:0];
		w.now_time = $urandom();
		send_word(w);
	endtask

	task automatic send_eof(input logic [31:0] t);
		in_word_t w;
		w.operation = OP_EOF;
		w.pos_x = POS_W'($urandom());
		w.pos_y = POS_W'($urandom());
		w.now_time = t;
		send_word(w);
	endtask

	task automatic wait_idle();
		item_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (IDLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] d);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= d;
		@(posedge clk);
	endtask

	// unused upper bits of narrow registers carry junk
	task automatic set_zone(input int xa, input int xb, input int ya, input int yb,
			input logic [31:0] thr, input bit mir, input bit en);
		int yae, ybe;
		wait_idle();
		write_reg(REG_X_BOUND_A, ($urandom() & ~32'hFFF) | xa);
		write_reg(REG_X_BOUND_B, ($urandom() & ~32'hFFF) | xb);
		write_reg(REG_Y_BOUND_A, ($urandom() & ~32'hFFF) | ya);
		write_reg(REG_Y_BOUND_B, ($urandom() & ~32'hFFF) | yb);
		write_reg(REG_DWELL_THRESHOLD, thr);
		write_reg(REG_MIRROR_Y, ($urandom() & ~32'h1) | 32'(mir));
		write_reg(REG_ZONE_ON, ($urandom() & ~32'h1) | 32'(en));
		write_reg(REG_UNUSED, $urandom());
		cfg_we <= 1'b0;
		yae = mir ? int'(FIELD_HEIGHT) - ya : ya;
		ybe = mir ? int'(FIELD_HEIGHT) - yb : yb;
		g_xlo = (xa < xb) ? xa : xb;
		g_xhi = (xa < xb) ? xb : xa;
		g_ylo = (yae < ybe) ? yae : ybe;
		g_yhi = (yae < ybe) ? ybe : yae;
		settings_used++;
	endtask

	function automatic void pick_inside(output int x, output int y);
		x = g_xlo + $urandom_range(0, g_xhi - g_xlo);
		y = g_ylo + $urandom_range(0, g_yhi - g_ylo);
		case ($urandom_range(0, 7))
			0: x = g_xlo;
			1: x = g_xhi;
			2: y = g_ylo;
			3: y = g_yhi;
			default: ;
		endcase
	endfunction

	function automatic void pick_outside_edge(output int x, output int y);
		pick_inside(x, y);
		case ($urandom_range(0, 3))
			0: x = g_xlo - 1;
			1: x = g_xhi + 1;
			2: y = g_ylo - 1;
			default: y = g_yhi + 1;
		endcase
	endfunction

	function automatic int pick_bound();
		int r;
		r = $urandom_range(0, 99);
		if (r < 15)
			return 0;
		else if (r < 30)
			return 4095;
		else if (r < 50)
			return $urandom_range(0, 64);
		else
			return $urandom_range(0, 4095);
	endfunction

	function automatic logic [31:0] pick_threshold();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0, 1: return 32'd0;
			2: return 32'd1;
			3: return 32'hFFFF_FFFF;
			4, 5: return $urandom();
			default: return $urandom_range(1, 60);
		endcase
	endfunction

	task automatic test_disabled_zone();
		set_zone(200, 100, 50, 60, 5, 0, 0);
		send_pos(150, 55);
		send_eof(10);
	endtask

	// inclusive edges, entry near wrap, dwell, exit, just-left ignores a hit
	task automatic test_bounds_and_dwell();
		set_zone(200, 100, 60, 50, 5, 0, 1);
		send_pos(100, 50);
		send_eof(32'hFFFF_FFF0);
		send_pos(200, 60);
		send_eof(2);
		send_pos(201, 60);
		send_pos(150, 61);
		send_pos(99, 49);
		send_pos(150, 49);
		send_eof(3);
		send_pos(150, 55);
		send_eof(4);
		send_eof(5);
	endtask

	task automatic test_mirror_and_extremes();
		set_zone(0, 4095, 4095, 0, 0, 1, 1);
		send_pos(-32768, -32768);
		send_pos(32767, 32767);
		send_pos(0, -2095);
		send_eof(100);
		send_pos(4095, 2000);
		send_eof(7);
		send_pos(4095, 2001);
		send_pos(-1, 0);
		send_eof(8);
		send_eof(9);
		set_zone(0, 0, 2000, 2000, 32'hFFFF_FFFF, 1, 1);
		send_pos(0, 0);
		send_eof(0);
		send_pos(0, 0);
		send_eof(32'hFFFF_FFFF);
	endtask

	// frames with runs of presence and absence under random zone settings
	task automatic test_random_frames();
		int p, start, n_pos, hit_at, k, x, y, run_left, r;
		bit present;
		for (p = 0; p < PHASES; p++) begin
			set_zone(pick_bound(), pick_bound(), pick_bound(), pick_bound(), pick_threshold(),
				1'($urandom_range(0, 1)), $urandom_range(0, 6) != 0);
			quiet <= ($urandom_range(0, 4) == 0);
			cur_time = $urandom();
			run_left = 0;
			present = 0;
			start = words_sent;
			while (words_sent - start < PHASE_WORDS) begin
				if (run_left == 0) begin
					present = !present;
					run_left = present ? $urandom_range(1, 8) : $urandom_range(1, 3);
				end
				run_left--;
				n_pos = $urandom_range(0, 4);
				if (present && n_pos == 0)
					n_pos = 1;
				hit_at = (n_pos > 0) ? $urandom_range(0, n_pos - 1) : 0;
				for (k = 0; k < n_pos; k++) begin
					r = $urandom_range(0, 99);
					if ((present && k == hit_at) || r < 5) begin
						pick_inside(x, y);
					end else if (r < 55) begin
						pick_outside_edge(x, y);
					end else if (r < 75 && present) begin
						pick_inside(x, y);
					end else begin
						x = $urandom();
						y = $urandom();
					end
					send_pos(x, y);
				end
				case ($urandom_range(0, 9))
					0: ;
					1: cur_time = cur_time + $urandom();
					2: cur_time = 32'hFFFF_FFFF - $urandom_range(0, 30);
					default: cur_time = cur_time + $urandom_range(1, 20);
				endcase
				send_eof(cur_time);
			end
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_disabled_zone();
		test_bounds_and_dwell();
		test_mirror_and_extremes();
		test_random_frames();
		item_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("sent %0d input words under %0d zone settings, checked %0d result words",
			words_sent, settings_used, results_checked);
		$display("saw %0d entries, %0d dwell events and %0d exits", n_entered, n_dwell, n_left);
		if (err_count == 0)
			$display("zone_occupancy_dwell_monitor_top test passed");
		else
			$display("zone_occupancy_dwell_monitor_top test failed");
		$finish;
	end

endmodule

`default_nettype wire
